FILE: hw/rtl/rate_limited_heading_follower_core_assert.svh
// Assertion macros for the heading follower checker.
// Each macro expects clk and rst to be visible where it is used.
`ifndef RATE_LIMITED_HEADING_FOLLOWER_CORE_ASSERT_SVH
`define RATE_LIMITED_HEADING_FOLLOWER_CORE_ASSERT_SVH

// Condition now implies consequence in the same cycle.
`define RLHF_ASSERT_NOW(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("rlhf assertion failed");

// Condition now implies consequence in the next cycle.
`define RLHF_ASSERT_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("rlhf assertion failed");

`endif

FILE: hw/rtl/rlhf_pkg.sv
// Shared types and constants for the heading follower.
// No dependencies.
package rlhf_pkg;

  localparam int ZFRAC     = 20;
  localparam int MAX_TABLE = 24;
  localparam int MOD_TOP   = 5;
  localparam logic signed [30:0] INV_GAIN_Q28 = 31'sd163008219;
  localparam logic signed [31:0] HALF_TURN_Z  = 32'sd188743680;

  localparam logic [1:0] REG_OFFSET = 2'd0;
  localparam logic [1:0] REG_SPEED  = 2'd1;
  localparam logic [1:0] REG_PULL   = 2'd2;

  // atan(2^-i) in degrees, scaled by 2^20
  localparam logic [31:0] ATAN_TAB [MAX_TABLE] = '{
    32'd47185920, 32'd27855475, 32'd14718068, 32'd7471121, 32'd3750058,
    32'd1876857, 32'd938658, 32'd469357, 32'd234682, 32'd117342, 32'd58671,
    32'd29335, 32'd14668, 32'd7334, 32'd3667, 32'd1833, 32'd917, 32'd458,
    32'd229, 32'd115, 32'd57, 32'd29, 32'd14, 32'd7
  };

  function automatic logic signed [31:0] atan_val(input logic [4:0] idx);
    logic signed [31:0] v;
    v = 32'sd0;
    if (idx < 5'(MAX_TABLE)) v = signed'(ATAN_TAB[idx]);
    return v;
  endfunction

  typedef struct packed {
    logic [16:0] offset;
    logic [22:0] speed;
    logic [14:0] pull;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic       round;
    logic       bias;
    logic       mod_step;
    logic       update;
    logic       finish;
    logic [4:0] idx;
  } cmd_t;

endpackage

FILE: hw/rtl/rlhf_regs.sv
// APB configuration registers of the heading follower.
// Depends on rlhf_pkg.
module rlhf_regs (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output rlhf_pkg::cfg_t   cfg
);
  import rlhf_pkg::*;

  logic wr;
  assign wr = psel && penable && pwrite;

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      case (paddr[3:2])
        REG_OFFSET: cfg.offset <= pwdata[16:0];
        REG_SPEED:  cfg.speed  <= pwdata[22:0];
        REG_PULL:   cfg.pull   <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (paddr[3:2])
      REG_OFFSET: prdata = {{15{cfg.offset[16]}}, cfg.offset};
      REG_SPEED:  prdata = {9'd0, cfg.speed};
      REG_PULL:   prdata = {17'd0, cfg.pull};
      default:    prdata = 32'd0;
    endcase
  end
endmodule

FILE: hw/rtl/rlhf_ctrl.sv
// Sequencer for the heading follower: steps the CORDIC and the heading wrap.
// Depends on rlhf_pkg.
module rlhf_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output rlhf_pkg::cmd_t cmd
);
  import rlhf_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_STEP  = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_BIAS  = 3'd3;
  localparam logic [2:0] S_MOD   = 3'd4;
  localparam logic [2:0] S_UPD   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state, state_next;
  logic [4:0] cnt, cnt_next;

  assign in_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.idx    = cnt;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = 5'd0;
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        cmd.step = 1'b1;
        if (cnt == 5'(CORDIC_STEPS - 1)) begin
          state_next = S_ROUND;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      S_ROUND: begin
        cmd.round  = 1'b1;
        state_next = S_BIAS;
      end
      S_BIAS: begin
        cmd.bias   = 1'b1;
        cnt_next   = 5'(MOD_TOP);
        state_next = S_MOD;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (cnt == 5'd0) begin
          state_next = S_UPD;
        end else begin
          cnt_next = cnt - 5'd1;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state and result flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= 5'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.finish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end
endmodule

FILE: hw/rtl/rlhf_dp.sv
// Datapath of the heading follower: CORDIC, heading wrap and clamp, crosshair.
// Depends on rlhf_pkg; driven by rlhf_ctrl commands.
module rlhf_dp #(
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  rlhf_pkg::cmd_t     cmd,
  input  rlhf_pkg::cfg_t     cfg,
  input  logic signed [15:0] own_x,
  input  logic signed [15:0] own_y,
  input  logic signed [15:0] aim_x,
  input  logic signed [15:0] aim_y,
  input  logic [15:0]        elapsed,
  output logic [15:0]        new_heading,
  output logic signed [15:0] dir_x,
  output logic signed [15:0] dir_y,
  output logic signed [15:0] mark_x,
  output logic signed [15:0] mark_y
);
  import rlhf_pkg::*;

  localparam int FULL  = 360 << ANGLE_FRAC_BITS;
  localparam int HALF  = 180 << ANGLE_FRAC_BITS;
  localparam int HW    = $clog2(FULL);
  localparam int RW    = HW + 2;
  localparam int MW    = HW + 8;
  localparam int CW    = 26;
  localparam int XW    = 44;
  localparam int SH    = ZFRAC - ANGLE_FRAC_BITS;
  localparam logic [MW-1:0] FULL_M = MW'(FULL);
  localparam logic [MW-1:0] BIAS_M = MW'(FULL) << MOD_TOP;
  localparam logic signed [31:0] ZRND = 32'sd1 <<< (SH - 1);

  logic signed [XW-1:0] x, y;
  logic signed [31:0]   z;
  logic signed [30:0]   rx, ry;
  logic                 flip, zero;
  logic signed [15:0]   ax, ay;
  logic [22:0]          maxstep;
  logic signed [RW-1:0] raw;
  logic signed [15:0]   dx_r, dy_r;
  logic [MW-1:0]        rem;
  logic [HW-1:0]        heading;
  logic signed [31:0]   prodx, prody;

  // Load: difference vector, half-plane fold, turn limit
  logic signed [16:0] dx, dy, ndx, ndy;
  logic [38:0]        turn;
  always_comb begin
    dx   = {aim_x[15], aim_x} - {own_x[15], own_x};
    dy   = {aim_y[15], aim_y} - {own_y[15], own_y};
    ndx  = dx[16] ? -dx : dx;
    ndy  = dx[16] ? -dy : dy;
    turn = cfg.speed * elapsed;
  end

  // CORDIC micro-rotation
  logic signed [XW-1:0] xs, ys;
  logic signed [30:0]   rxs, rys;
  logic signed [31:0]   at;
  always_comb begin
    xs  = x >>> cmd.idx;
    ys  = y >>> cmd.idx;
    rxs = rx >>> cmd.idx;
    rys = ry >>> cmd.idx;
    at  = atan_val(cmd.idx);
  end

  // Rounding of angle and direction
  logic signed [31:0] zr;
  logic signed [30:0] rxn, ryn, rdx, rdy;
  always_comb begin
    zr  = (z + ZRND) >>> SH;
    rxn = flip ? -rx : rx;
    ryn = flip ? -ry : ry;
    rdx = (rxn + 31'sd8192) >>> 14;
    rdy = (ryn + 31'sd8192) >>> 14;
  end

  function automatic logic signed [15:0] sat_dir(input logic signed [30:0] v);
    logic signed [15:0] r;
    if (v > 31'sd16384) r = 16'sd16384;
    else if (v < -31'sd16384) r = -16'sd16384;
    else r = 16'(v);
    return r;
  endfunction

  // Bias into nonnegative range, then reduction step
  logic [MW-1:0] vbias, sub;
  always_comb begin
    vbias = {{(MW-RW){raw[RW-1]}}, raw} + {{(MW-17){cfg.offset[16]}}, cfg.offset}
          - {{(MW-HW){1'b0}}, heading} + BIAS_M;
    sub   = FULL_M << cmd.idx;
  end

  // Shortest turn, clamp, wrap
  logic signed [CW-1:0] d, dcl, mx, hs;
  logic signed [15:0]   pull_s;
  always_comb begin
    d = signed'({{(CW-HW){1'b0}}, rem[HW-1:0]});
    if (d > CW'(HALF)) d = d - CW'(FULL);
    mx = signed'({{(CW-23){1'b0}}, maxstep});
    if (d > mx) dcl = mx;
    else if (d < -mx) dcl = -mx;
    else dcl = d;
    hs = signed'({{(CW-HW){1'b0}}, heading}) + dcl;
    if (hs < 0) hs = hs + CW'(FULL);
    else if (hs >= CW'(FULL)) hs = hs - CW'(FULL);
    pull_s = signed'({1'b0, cfg.pull});
  end

  // Crosshair pullback and saturation
  logic signed [31:0] px, py, mxw, myw;
  logic [31:0]        hz;
  always_comb begin
    px  = (prodx + 32'sd8192) >>> 14;
    py  = (prody + 32'sd8192) >>> 14;
    mxw = 32'(ax) - px;
    myw = 32'(ay) - py;
    hz  = 32'(heading);
  end

  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd32767) r = 16'sd32767;
    else if (v < -32'sd32768) r = -16'sd32768;
    else r = 16'(v);
    return r;
  endfunction

  // Heading state
  always_ff @(posedge clk) begin
    if (rst) heading <= '0;
    else if (cmd.update) heading <= HW'(hs);
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      flip    <= dx[16];
      zero    <= (dx == 17'sd0) && (dy == 17'sd0);
      x       <= {{(XW-41){ndx[16]}}, ndx, 24'd0};
      y       <= {{(XW-41){ndy[16]}}, ndy, 24'd0};
      z       <= dx[16] ? (dy[16] ? -HALF_TURN_Z : HALF_TURN_Z) : 32'sd0;
      rx      <= INV_GAIN_Q28;
      ry      <= 31'sd0;
      ax      <= aim_x;
      ay      <= aim_y;
      maxstep <= turn[38:16];
    end
    if (cmd.step) begin
      if (!y[XW-1]) begin
        x <= x + ys; y <= y - xs; z <= z + at;
        rx <= rx - rys; ry <= ry + rxs;
      end else begin
        x <= x - ys; y <= y + xs; z <= z - at;
        rx <= rx + rys; ry <= ry - rxs;
      end
    end
    if (cmd.round) begin
      raw  <= zero ? '0 : RW'(zr);
      dx_r <= zero ? 16'sd0 : sat_dir(rdx);
      dy_r <= zero ? 16'sd0 : sat_dir(rdy);
    end
    if (cmd.bias) rem <= vbias;
    if (cmd.mod_step && rem >= sub) rem <= rem - sub;
    if (cmd.update) begin
      prodx <= dx_r * pull_s;
      prody <= dy_r * pull_s;
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      new_heading <= hz[15:0];
      dir_x       <= dx_r;
      dir_y       <= dy_r;
      mark_x      <= sat16(mxw);
      mark_y      <= sat16(myw);
    end
  end
endmodule

FILE: hw/rtl/rate_limited_heading_follower_core.sv
// One item runs at a time: after the accept, the shared CORDIC stage steps once
// a cycle, followed by round, bias, six reduction steps, update and hand-off.
// A new input is taken only once the last result is in the output register.
// A finished result waits in the output register while the next item runs.
// Reset (rst, synchronous, active high) clears heading, config registers and control.
module rate_limited_heading_follower_core #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] own_x,
  input  logic signed [15:0] own_y,
  input  logic signed [15:0] aim_x,
  input  logic signed [15:0] aim_y,
  input  logic [15:0]        elapsed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        new_heading,
  output logic signed [15:0] dir_x,
  output logic signed [15:0] dir_y,
  output logic signed [15:0] mark_x,
  output logic signed [15:0] mark_y
);
  import rlhf_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  assign pready = 1'b1;

  rlhf_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
  );

  rlhf_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .cmd
  );

  rlhf_dp #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_dp (
    .clk, .rst, .cmd, .cfg, .own_x, .own_y, .aim_x, .aim_y, .elapsed,
    .new_heading, .dir_x, .dir_y, .mark_x, .mark_y
  );
endmodule

FILE: hw/rtl/rlhf_checker.sv
// Port-level checks for the heading follower, bound to the top level.
// Depends on rate_limited_heading_follower_core_assert.svh.
`include "rate_limited_heading_follower_core_assert.svh"

module rlhf_checker #(
  parameter int ANGLE_FRAC_BITS = 7
) (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [15:0]        new_heading,
  input logic signed [15:0] dir_x,
  input logic signed [15:0] dir_y
);
  localparam logic [16:0] FULL16 = 17'(360 << ANGLE_FRAC_BITS);

  logic dir_ok;
  assign dir_ok = dir_x >= -16'sd16384 && dir_x <= 16'sd16384 &&
                  dir_y >= -16'sd16384 && dir_y <= 16'sd16384;

  // A stalled result stays offered
  `RLHF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // One item in work: busy right after an input transaction
  `RLHF_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready)
  // Heading lies within one turn
  `RLHF_ASSERT_NOW(a_heading, out_valid, ANGLE_FRAC_BITS > 7 || {1'b0, new_heading} < FULL16)
  // Direction stays within unit length per axis
  `RLHF_ASSERT_NOW(a_dir, out_valid, dir_ok)
endmodule

bind rate_limited_heading_follower_core rlhf_checker #(
  .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
) u_rlhf_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
  .new_heading, .dir_x, .dir_y
);

FILE: verif/rate_limited_heading_follower_core_checker.sv
// Checker for the heading follower: watches both channels and the APB port,
// predicts each result from its own copy of heading and registers, compares.
// Depends on rlhf_pkg for register indexes.
`timescale 1ns / 100ps
module rate_limited_heading_follower_core_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] own_x,
  input  logic signed [15:0] own_y,
  input  logic signed [15:0] aim_x,
  input  logic signed [15:0] aim_y,
  input  logic [15:0]        elapsed,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [15:0]        new_heading,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [15:0] mark_x,
  input  logic signed [15:0] mark_y,
  output int                 fail_count,
  output int                 pending,
  output int                 seen
);
  import rlhf_pkg::*;

  localparam longint FULL_TURN = 360 * 128;
  localparam longint HALF_TURN = 180 * 128;

  typedef struct packed {
    logic [15:0] heading;
    logic [15:0] dx;
    logic [15:0] dy;
    logic [15:0] mx;
    logic [15:0] my;
  } steer_t;

  // atan(2^-i) in degrees scaled by 2^20
  localparam longint ATANS [16] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833
  };

  steer_t          steer_q[$];
  longint          offs, pull, track;
  longint unsigned speed;

  // Floor shift; >>> on signed longint already floors.
  function automatic longint fsr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint wrap_turn(longint v);
    longint r;
    r = v % FULL_TURN;
    if (r < 0) r += FULL_TURN;
    return r;
  endfunction

  // Compute the next steering result and advance the tracked heading.
  function automatic steer_t steer_predict(longint ox, longint oy, longint ax,
                                           longint ay, longint el);
    longint dx, dy, x, y, z, rx, ry, xs, ys, rxs, rys, raw, ux, uy, diff, lim;
    bit flip;
    steer_t r;
    dx = ax - ox; dy = ay - oy;
    raw = 0; ux = 0; uy = 0;
    if (dx != 0 || dy != 0) begin
      flip = dx < 0;
      x = (flip ? -dx : dx) <<< 24;
      y = (flip ? -dy : dy) <<< 24;
      z = flip ? ((dy >= 0 ? 180 : -180) <<< 20) : 0;
      rx = 163008219; ry = 0;
      for (int i = 0; i < 16; i++) begin
        xs = fsr(x, i); ys = fsr(y, i); rxs = fsr(rx, i); rys = fsr(ry, i);
        if (y >= 0) begin
          x += ys; y -= xs; z += ATANS[i]; rx -= rys; ry += rxs;
        end else begin
          x -= ys; y += xs; z -= ATANS[i]; rx += rys; ry -= rxs;
        end
      end
      if (flip) begin
        rx = -rx; ry = -ry;
      end
      raw = fsr(z + (1 <<< 12), 13);
      ux = clip(fsr(rx + (1 <<< 13), 14), -16384, 16384);
      uy = clip(fsr(ry + (1 <<< 13), 14), -16384, 16384);
    end
    diff = wrap_turn(raw + offs - track);
    lim = longint'((speed * longint'(el)) >> 16);
    if (diff > HALF_TURN) diff -= FULL_TURN;
    diff = clip(diff, -lim, lim);
    track = wrap_turn(track + diff);
    r.heading = track[15:0];
    r.dx = ux[15:0];
    r.dy = uy[15:0];
    xs = clip(ax - fsr(ux * pull + (1 <<< 13), 14), -32768, 32767);
    ys = clip(ay - fsr(uy * pull + (1 <<< 13), 14), -32768, 32767);
    r.mx = xs[15:0];
    r.my = ys[15:0];
    return r;
  endfunction

  assign pending = steer_q.size();

  always @(posedge clk) begin
    steer_t want, got;
    if (rst) begin
      offs = 0; speed = 0; pull = 0; track = 0;
      fail_count <= 0; seen <= 0;
      steer_q.delete();
    end else begin
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_OFFSET: offs = longint'($signed(pwdata[16:0]));
          REG_SPEED:  speed = pwdata[22:0];
          REG_PULL:   pull = pwdata[14:0];
          default: ;
        endcase
      end
      // Compare output transaction against oldest prediction
      if (out_valid && out_ready) begin
        seen <= seen + 1;
        got = '{new_heading, dir_x, dir_y, mark_x, mark_y};
        if (steer_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = steer_q.pop_front();
          if (want != got) begin
            if (fail_count < 10) begin
              $display("mismatch exp hd=%0d d=(%0d,%0d) m=(%0d,%0d)",
                want.heading, $signed(want.dx), $signed(want.dy),
                $signed(want.mx), $signed(want.my));
              $display("         got hd=%0d d=(%0d,%0d) m=(%0d,%0d)",
                got.heading, $signed(got.dx), $signed(got.dy),
                $signed(got.mx), $signed(got.my));
            end
            fail_count <= fail_count + 1;
          end
        end
      end
      // Predict from accepted input transaction
      if (in_valid && in_ready)
        steer_q.push_back(steer_predict(own_x, own_y, aim_x, aim_y, elapsed));
    end
  end
endmodule

FILE: verif/rate_limited_heading_follower_core_tb.sv
// Top of the heading follower testbench: clock, reset, APB writes, stimulus
// with bursty sender and stalling receiver, verdict. Needs the checker module.
`timescale 1ns / 100ps
module rate_limited_heading_follower_core_tb;
  import rlhf_pkg::*;

  localparam int LATENCY = 26;
  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic signed [15:0] own_x = 0, own_y = 0, aim_x = 0, aim_y = 0;
  logic [15:0] elapsed = 0;
  logic [15:0] new_heading;
  logic signed [15:0] dir_x, dir_y, mark_x, mark_y;
  int fail_count, pending, seen, sent, idle_cycles;

  always #2 clk = ~clk;

  rate_limited_heading_follower_core dut (.*);

  rate_limited_heading_follower_core_checker chk (.*);

  // Receiver stalls: alternating free-running and stalling stretches
  always @(posedge clk) begin
    int phase;
    phase = ($urandom_range(0, 3) == 0) ? 1 : 0;
    if (rst) out_ready <= 1'b0;
    else if (seen % 200 < 60) out_ready <= 1'b1;
    else out_ready <= phase ? 1'b0 : ($urandom_range(0, 2) != 0);
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("watchdog expired, %0d results pending", pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // Drive one item and hold it until the transaction completes
  task automatic send_item(input logic [15:0] ox, oy, ax, ay, el);
    in_valid <= 1; own_x <= ox; own_y <= oy; aim_x <= ax; aim_y <= ay; elapsed <= el;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Random item: mostly small moves, sometimes full-range fields
  task automatic send_random();
    logic [15:0] ox, oy;
    if ($urandom_range(0, 3) == 0) begin
      send_item(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom));
    end else begin
      ox = 16'($urandom); oy = 16'($urandom);
      send_item(ox, oy, ox + 16'($urandom_range(0, 4000)) - 16'd2000,
                oy + 16'($urandom_range(0, 4000)) - 16'd2000,
                16'($urandom_range(0, 6000)));
    end
  endtask

  initial begin
    int burst;
    repeat (9) @(posedge clk);
    rst <= 0;

    // Directed: extremes, zero vector, axes, half turn, heading wrap
    reg_write(REG_SPEED, 32'h7FFFFF);
    reg_write(REG_PULL, 32'h7FFF);
    reg_write(REG_OFFSET, 32'h0);
    send_item(16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF);
    send_item(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'hFFFF);
    send_item(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'hFFFF);
    send_item(16'd0, 16'd0, 16'd100, 16'd0, 16'hFFFF);
    send_item(16'd0, 16'd0, -16'sd100, 16'd0, 16'hFFFF);
    send_item(16'd0, 16'd0, 16'd0, 16'd100, 16'hFFFF);
    send_item(16'd0, 16'd0, 16'd0, -16'sd100, 16'hFFFF);
    send_item(16'd0, 16'd0, -16'sd100, -16'sd1, 16'hFFFF);
    send_item(16'd0, 16'd0, 16'h7FFF, 16'h8000, 16'd0);
    send_item(16'd0, 16'd0, 16'h8000, 16'h7FFF, 16'hFFFF);
    send_item(16'd5, 16'd5, 16'd5, 16'd5, 16'hFFFF);
    drain();
    reg_write(REG_OFFSET, 32'h0000B400);
    reg_write(REG_SPEED, 32'h100);
    send_item(16'd0, 16'd0, 16'd10, 16'd10, 16'hFFFF);
    send_item(16'd0, 16'd0, -16'sd10, 16'd10, 16'h8000);
    send_item(16'd0, 16'd0, 16'd0, 16'd0, 16'd1);
    drain();
    reg_write(REG_OFFSET, 32'h1_4C00);
    reg_write(REG_PULL, 32'd0);
    reg_write(REG_SPEED, 32'd0);
    send_item(16'd0, 16'd0, 16'd30, -16'sd7, 16'hFFFF);
    send_item(16'h7FFF, 16'd0, 16'h8000, 16'd0, 16'hFFFF);
    drain();

    // Random phases with varied configuration
    for (int ph = 0; ph < 6; ph++) begin
      reg_write(REG_OFFSET, (ph == 0) ? 32'h1_4C00 : (ph == 1) ? 32'h0B400 :
                $urandom_range(0, 92160) - 46080);
      reg_write(REG_SPEED, (ph == 2) ? 32'h7FFFFF : (ph == 3) ? 0 : $urandom);
      reg_write(REG_PULL, (ph == 4) ? 32'h7FFF : (ph == 5) ? 0 : $urandom);
      for (int n = 0; n < 300; ) begin
        burst = $urandom_range(1, 25);
        for (int b = 0; b < burst && n < 300; b++, n++) send_random();
        in_valid <= 0;
        if (n == 150 && ph == 2) while (pending != 0) @(posedge clk);
        repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 60)) @(posedge clk);
      end
      drain();
    end

    $display("sent %0d items, checked %0d results across 9 register settings",
             sent, seen);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
